// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dns_pkg.sv =====
// Types, constants and helper functions of the disc neighborhood scan.
package dns_pkg;

    // Coordinate and radius sizing.
    localparam int COORD_BITS          = 12;
    localparam int DIM_BITS            = COORD_BITS + 1;
    localparam int RAD_BITS            = 5;
    localparam int MAX_RADIUS_QUARTERS = 17;
    localparam int MAX_EXT             = MAX_RADIUS_QUARTERS / 4;
    localparam int EXT_BITS            = $clog2(MAX_EXT + 1);
    localparam int SQ_BITS             = 2 * RAD_BITS;

    // Grid limit and reset values.
    localparam logic [DIM_BITS-1:0] DIM_LIMIT = DIM_BITS'(1 << COORD_BITS);
    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(128);

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 1'b1;

    // Column queue sizing.
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Request transaction.
    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [RAD_BITS-1:0]   radius_quarters;
    } t_req;

    // Result transaction.
    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  last_point;
        logic                  bad_center;
    } t_res;

    // One column of the disc, handed from the front part to the back part.
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] ylo;
        logic [COORD_BITS-1:0] yhi;
        logic                  last;
        logic                  bad;
    } t_col;

    // Queue status seen by the producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Vertical extent of a column: the largest e with 16*(e*e + adx*adx) <= q*q,
    // which equals floor(isqrt(q*q - 16*adx*adx) / 4).
    function automatic logic [EXT_BITS-1:0] ext_of(input logic [RAD_BITS-1:0] q,
                                                  input logic [EXT_BITS-1:0] adx);
        logic [SQ_BITS-1:0]  qq;
        logic [EXT_BITS-1:0] e;
        int                  lhs;
        qq = {{RAD_BITS{1'b0}}, q} * {{RAD_BITS{1'b0}}, q};
        e  = '0;
        for (int k = 1; k <= MAX_EXT; k++) begin
            lhs = 16 * (k * k + int'(adx) * int'(adx));
            if (lhs <= int'(qq)) begin
                e = EXT_BITS'(k);
            end
        end
        return e;
    endfunction

endpackage

// ===== hw/rtl/dns_front.sv =====
// Front part: takes a request, classifies the center and issues one column per cycle while the queue has room.
module dns_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  dns_pkg::t_req                i_req,
    input  logic [dns_pkg::DIM_BITS-1:0] i_grid_width,
    input  logic [dns_pkg::DIM_BITS-1:0] i_grid_height,
    input  dns_pkg::t_fifo_stat          i_fifo_stat,
    output logic                         o_push,
    output dns_pkg::t_col                o_col,
    output logic                         o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLASSIFY,
        S_COLS
    } t_state;

    t_state r_state;
    logic [dns_pkg::COORD_BITS-1:0] r_cx;
    logic [dns_pkg::COORD_BITS-1:0] r_cy;
    logic [dns_pkg::RAD_BITS-1:0]   r_q;
    logic [dns_pkg::COORD_BITS-1:0] r_h1;
    logic [dns_pkg::COORD_BITS-1:0] r_x;
    logic [dns_pkg::COORD_BITS-1:0] r_xhi;
    logic                           r_bad;

    logic [dns_pkg::RAD_BITS-1:0]   q_clamped;
    logic [dns_pkg::DIM_BITS-1:0]   w_eff;
    logic [dns_pkg::DIM_BITS-1:0]   h_eff;
    logic                           bad;
    logic [dns_pkg::COORD_BITS-1:0] rc;
    logic [dns_pkg::COORD_BITS-1:0] xlo;
    logic [dns_pkg::DIM_BITS-1:0]   xhi_raw;
    logic [dns_pkg::DIM_BITS-1:0]   w_m1;
    logic [dns_pkg::COORD_BITS-1:0] xhi;
    logic [dns_pkg::COORD_BITS-1:0] adx_full;
    logic [dns_pkg::EXT_BITS-1:0]   ext;
    logic [dns_pkg::COORD_BITS-1:0] ext_w;
    logic [dns_pkg::DIM_BITS-1:0]   yhi_raw;
    logic                           col_last;

    // Radius saturates at the cap.
    assign q_clamped = (i_req.radius_quarters > dns_pkg::RAD_BITS'(dns_pkg::MAX_RADIUS_QUARTERS))
                     ? dns_pkg::RAD_BITS'(dns_pkg::MAX_RADIUS_QUARTERS)
                     : i_req.radius_quarters;

    // Classification: effective grid size, bad center and clipped column range.
    always_comb begin
        w_eff   = (i_grid_width  < dns_pkg::DIM_LIMIT) ? i_grid_width  : dns_pkg::DIM_LIMIT;
        h_eff   = (i_grid_height < dns_pkg::DIM_LIMIT) ? i_grid_height : dns_pkg::DIM_LIMIT;
        bad     = ({1'b0, r_cx} >= w_eff) || ({1'b0, r_cy} >= h_eff);
        rc      = dns_pkg::COORD_BITS'(r_q >> 2);
        xlo     = r_cx - ((r_cx < rc) ? r_cx : rc);
        w_m1    = w_eff - dns_pkg::DIM_BITS'(1);
        xhi_raw = {1'b0, r_cx} + {1'b0, rc};
        xhi     = (xhi_raw < w_m1) ? xhi_raw[dns_pkg::COORD_BITS-1:0]
                                   : w_m1[dns_pkg::COORD_BITS-1:0];
    end

    // Column descriptor for the current x.
    always_comb begin
        adx_full = (r_x >= r_cx) ? (r_x - r_cx) : (r_cx - r_x);
        ext      = dns_pkg::ext_of(r_q, adx_full[dns_pkg::EXT_BITS-1:0]);
        ext_w    = dns_pkg::COORD_BITS'(ext);
        yhi_raw  = {1'b0, r_cy} + {1'b0, ext_w};
        col_last = r_bad || (r_x == r_xhi);
        o_col.x    = r_bad ? '0 : r_x;
        o_col.ylo  = r_bad ? '0 : (r_cy - ((r_cy < ext_w) ? r_cy : ext_w));
        o_col.yhi  = r_bad ? '0 : ((yhi_raw < {1'b0, r_h1}) ? yhi_raw[dns_pkg::COORD_BITS-1:0]
                                                            : r_h1);
        o_col.last = col_last;
        o_col.bad  = r_bad;
    end

    assign o_push = (r_state == S_COLS) && !i_fifo_stat.full;
    assign o_busy = (r_state != S_IDLE);

    // Sequencer: capture, classify, then one column per cycle while the queue has room.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_cx    <= i_req.center_x;
                        r_cy    <= i_req.center_y;
                        r_q     <= q_clamped;
                        r_state <= S_CLASSIFY;
                    end
                end
                S_CLASSIFY: begin
                    r_bad   <= bad;
                    r_x     <= xlo;
                    r_xhi   <= xhi;
                    r_h1    <= dns_pkg::COORD_BITS'(h_eff - dns_pkg::DIM_BITS'(1));
                    r_state <= S_COLS;
                end
                S_COLS: begin
                    if (o_push) begin
                        if (col_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_x <= r_x + dns_pkg::COORD_BITS'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/dns_fifo.sv =====
// Short queue of column descriptors between the front and back parts.
module dns_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dns_pkg::t_col       i_data,
    input  logic                i_pop,
    output dns_pkg::t_col       o_data,
    output dns_pkg::t_fifo_stat o_stat
);

    dns_pkg::t_col                     r_mem [dns_pkg::FIFO_DEPTH];
    logic [dns_pkg::FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [dns_pkg::FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [dns_pkg::FIFO_CNT_BITS-1:0] r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_stat.full  = (r_count == dns_pkg::FIFO_CNT_BITS'(dns_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + dns_pkg::FIFO_PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + dns_pkg::FIFO_PTR_BITS'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + dns_pkg::FIFO_CNT_BITS'(1);
                2'b01:   r_count <= r_count - dns_pkg::FIFO_CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/dns_back.sv =====
// Back part: walks each queued column row by row and drives one result per cycle while a column is loaded.
module dns_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dns_pkg::t_col       i_col,
    input  dns_pkg::t_fifo_stat i_fifo_stat,
    output logic                o_pop,
    output logic                o_active,
    output logic                o_strobe,
    output dns_pkg::t_res       o_res
);

    dns_pkg::t_col                  r_col;
    logic [dns_pkg::COORD_BITS-1:0] r_y;
    logic                           r_active;
    logic                           r_strobe;
    dns_pkg::t_res                  r_res;
    logic                           col_done;

    // A column ends on its top row; the next one, if queued, loads without a gap.
    assign col_done = r_active && (r_y == r_col.yhi);
    assign o_pop    = (!r_active || col_done) && !i_fifo_stat.empty;
    assign o_active = r_active;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_res.point_x    <= r_col.x;
            r_res.point_y    <= r_y;
            r_res.last_point <= r_col.last && col_done;
            r_res.bad_center <= r_col.bad;
        end
    end

    // Column walker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (o_pop) begin
                r_col    <= i_col;
                r_y      <= i_col.ylo;
                r_active <= 1'b1;
            end else if (col_done) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                r_y <= r_y + dns_pkg::COORD_BITS'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/disc_neighborhood_scan_core.sv =====
// Top level of the disc neighborhood scan: configuration, front, queue and back.
//
//  Channel   Handshake                   Payload
//  -------   -------------------------   ----------------------------------
//  request   start & !busy               i_req (center_x, center_y, radius)
//  result    o_res_strobe, one cycle     o_res (point_x, point_y, flags)
//  config    i_cfg_we                    i_cfg_idx, i_cfg_data
//
// A request is first set up (classify, queue the first column, load the walker), then gives
// one result per cycle, up to 61 results; the back part's one-row-per-cycle walk sets the rate.
// A bad center gives a single result.
// Reset is synchronous and active low; the grid registers come up at 128 by 128.
// The receiver cannot stall; the queue only paces the front part to the back part.
// busy drops while the last result is on the output, so a new request may follow.
`include "assert_macros.svh"

module disc_neighborhood_scan_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  dns_pkg::t_req                    i_req,
    output logic                             o_res_strobe,
    output dns_pkg::t_res                    o_res,
    input  logic                             i_cfg_we,
    input  logic [dns_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [dns_pkg::DIM_BITS-1:0]     i_cfg_data
);

    logic [dns_pkg::DIM_BITS-1:0] r_grid_width;
    logic [dns_pkg::DIM_BITS-1:0] r_grid_height;
    logic                         accept;
    logic                         front_busy;
    logic                         back_active;
    logic                         push;
    logic                         pop;
    dns_pkg::t_col                push_col;
    dns_pkg::t_col                head_col;
    dns_pkg::t_fifo_stat          fifo_stat;
    logic                         chk_bad;
    logic                         chk_zero_xy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= dns_pkg::DIM_RESET;
            r_grid_height <= dns_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dns_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                dns_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A request transaction is taken only when nothing is in flight.
    assign busy   = front_busy || !fifo_stat.empty || back_active;
    assign accept = start && !busy;

    dns_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_req         (i_req),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_fifo_stat   (fifo_stat),
        .o_push        (push),
        .o_col         (push_col),
        .o_busy        (front_busy)
    );

    dns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_col),
        .i_pop   (pop),
        .o_data  (head_col),
        .o_stat  (fifo_stat)
    );

    dns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_col       (head_col),
        .i_fifo_stat (fifo_stat),
        .o_pop       (pop),
        .o_active    (back_active),
        .o_strobe    (o_res_strobe),
        .o_res       (o_res)
    );

    // Checks.
    assign chk_bad     = o_res_strobe && o_res.bad_center;
    assign chk_zero_xy = (o_res.point_x == '0) && (o_res.point_y == '0);

    `DNS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, busy, "busy low after accept")
    `DNS_ASSERT_NOW(a_strobe_busy, i_clk, i_rst_n, o_res_strobe, $past(busy), "result while idle")
    `DNS_ASSERT_NOW(a_bad_is_last, i_clk, i_rst_n, chk_bad, o_res.last_point, "bad center not last")
    `DNS_ASSERT_NOW(a_bad_zero_xy, i_clk, i_rst_n, chk_bad, chk_zero_xy, "bad center has xy")

endmodule
